// File: hw/rtl/lsbb_pkg.sv
// ----------------------------------------------------------------------------
// Log spectrum band binner package
// Sizes, queue entry type and the band edge and reciprocal log tables, which
// are built at elaboration.
// ----------------------------------------------------------------------------
package lsbb_pkg;

  localparam int NUM_BANDS     = 28;
  localparam int FFT_BINS      = 1024;
  localparam int EDGE_SPAN     = $clog2(FFT_BINS);
  localparam int GAIN_W        = 16;
  localparam int BIN_VAL_W     = 16;
  localparam int IDX_W         = 6;
  localparam int LEVEL_W       = 10;
  localparam int LEVEL_CAP     = 256;
  localparam int LEVEL_FRAC    = 24;
  localparam int ROOT_SHIFT    = 16;
  localparam int RLOG_W        = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd435;
  localparam logic [63:0] LOG10_2_Q32 = 64'd1292913986;
  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  localparam int BAND_W  = $clog2(NUM_BANDS + 1);
  localparam int BIN_W   = $clog2(FFT_BINS + NUM_BANDS);
  localparam int SUM_W   = BIN_VAL_W + $clog2(FFT_BINS);
  localparam int T_W     = SUM_W + RLOG_W;
  localparam int ROOT_W  = (T_W + ROOT_SHIFT + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int PR_W    = GAIN_W + ROOT_W;
  localparam int PROD_W  = (PR_W > T_W) ? PR_W : T_W;
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [RLOG_W-1:0] rlog;
    logic [BAND_W-1:0] band;
    logic              last;
  } entry_t;

  typedef logic [2**BAND_W-1:0][BIN_W-1:0]  edge_tab_t;
  typedef logic [2**BAND_W-1:0][RLOG_W-1:0] rlog_tab_t;

  function automatic int msb_pos(logic [31:0] v);
    int k;
    k = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) k = i;
    end
    return k;
  endfunction

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic pow_le(logic [31:0] e, int q, int p);
    int s;
    int ex;
    logic [63:0] me;
    logic [63:0] m;
    s = msb_pos(e);
    ex = 0;
    me = 64'(e) << (62 - s);
    m = ONE_Q62;
    for (int i = 0; i < q; i++) begin
      m = mul_q62(m, me);
      ex = ex + s;
      if (m[63]) begin
        m = m >> 1;
        ex = ex + 1;
      end
    end
    return (ex < p) || ((ex == p) && (m == ONE_Q62));
  endfunction

  function automatic logic [31:0] log2_q28(logic [31:0] n);
    int k;
    logic [63:0] y;
    logic [31:0] frac;
    k = msb_pos(n);
    y = 64'(n) << (30 - k);
    frac = '0;
    for (int i = 27; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac[i] = 1'b1;
      end
    end
    return (32'(k) << 28) | frac;
  endfunction

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic edge_tab_t build_edges();
    edge_tab_t tab;
    int e;
    int prev;
    int edge_v;
    tab = '0;
    e = 1;
    prev = 0;
    for (int x = 0; x < NUM_BANDS; x++) begin
      while ((e < FFT_BINS - 1) && pow_le(32'(e + 1), NUM_BANDS - 1, x * EDGE_SPAN)) begin
        e = e + 1;
      end
      edge_v = e;
      if (edge_v <= prev) edge_v = prev + 1;
      tab[x] = BIN_W'(edge_v);
      prev = edge_v;
    end
    return tab;
  endfunction

  function automatic rlog_tab_t build_rlogs(edge_tab_t edges);
    rlog_tab_t tab;
    logic [31:0] w;
    logic [31:0] prev;
    logic [63:0] lq;
    tab = '0;
    prev = '0;
    for (int x = 0; x < NUM_BANDS; x++) begin
      w = 32'(edges[x]) - prev;
      lq = (64'(log2_q28(32'd10 + w)) * LOG10_2_Q32) >> 32;
      tab[x] = RLOG_W'(udiv64((64'd1 << 44) + (lq >> 1), lq));
      prev = 32'(edges[x]);
    end
    return tab;
  endfunction

  localparam edge_tab_t EDGE_TAB = build_edges();
  localparam rlog_tab_t RLOG_TAB = build_rlogs(EDGE_TAB);

endpackage

// File: hw/rtl/lsbb_front.sv
// ----------------------------------------------------------------------------
// Band binner front end
// Counts bins, accumulates the current band and queues each finished band.
// ----------------------------------------------------------------------------
module lsbb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          full_i,
  input  logic [lsbb_pkg::BIN_VAL_W-1:0] bin_value_i,
  input  logic                          frame_start_i,
  output lsbb_pkg::entry_t              entry_o,
  output logic                          entry_valid_o
);
  import lsbb_pkg::*;

  logic [SUM_W-1:0]  sum_q, sum_d, sum_n;
  logic [BIN_W-1:0]  bin_q, bin_d, bin_n;
  logic [BAND_W-1:0] band_q, band_d;
  logic              accept, active, band_done;

  assign accept    = push_i && !full_i;
  assign active    = band_q < BAND_W'(NUM_BANDS);
  assign bin_n     = bin_q + BIN_W'(1);
  assign sum_n     = sum_q + SUM_W'(bin_value_i);
  assign band_done = accept && !frame_start_i && active && (bin_n >= EDGE_TAB[band_q]);

  assign entry_valid_o = band_done;
  assign entry_o.sum   = sum_n;
  assign entry_o.rlog  = RLOG_TAB[band_q];
  assign entry_o.band  = band_q;
  assign entry_o.last  = band_q == BAND_W'(NUM_BANDS - 1);

  always_comb begin
    sum_d  = sum_q;
    bin_d  = bin_q;
    band_d = band_q;
    if (accept) begin
      if (frame_start_i) begin
        sum_d  = '0;
        bin_d  = '0;
        band_d = '0;
      end else if (active) begin
        bin_d = bin_n;
        if (band_done) begin
          sum_d  = '0;
          band_d = band_q + BAND_W'(1);
        end else begin
          sum_d = sum_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      bin_q  <= '0;
      band_q <= '0;
    end else begin
      sum_q  <= sum_d;
      bin_q  <= bin_d;
      band_q <= band_d;
    end
  end

endmodule

// File: hw/rtl/lsbb_fifo.sv
// ----------------------------------------------------------------------------
// Band queue
// Short queue of finished bands between the front end and the level unit.
// ----------------------------------------------------------------------------
module lsbb_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsbb_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output lsbb_pkg::entry_t data_o,
  output logic             empty_o
);
  import lsbb_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  entry_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/lsbb_back.sv
// ----------------------------------------------------------------------------
// Band level unit
// Scales each band sum, takes a bit-serial square root, applies the gain and
// holds the result for the consumer.
// ----------------------------------------------------------------------------
module lsbb_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [lsbb_pkg::GAIN_W-1:0]        gain_i,
  input  lsbb_pkg::entry_t                   entry_i,
  input  logic                               entry_empty_i,
  output logic                               entry_pop_o,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic [lsbb_pkg::IDX_W-1:0]         band_index_o,
  output logic signed [lsbb_pkg::LEVEL_W-1:0] band_level_o,
  output logic                               last_band_o
);
  import lsbb_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SQRT  = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_LEVEL = 3'd4;
  localparam int CNT_W = $clog2(ROOT_W);
  localparam int HI_W  = PROD_W - LEVEL_FRAC;

  logic [2:0]          state_q, state_d;
  logic [SUM_W-1:0]    sum_q;
  logic [RLOG_W-1:0]   rlog_q;
  logic [BAND_W-1:0]   band_q;
  logic                last_q;
  logic [RAD_W-1:0]    rad_q;
  logic [REM_W-2:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [PROD_W-1:0]   prod_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic signed [LEVEL_W-1:0] out_lvl_q;
  logic                out_last_q;

  logic [T_W-1:0]      t_w;
  logic [REM_W:0]      rem_sh;
  logic [REM_W:0]      trial;
  logic                fits;
  logic [HI_W-1:0]     hi;
  logic [LEVEL_FRAC+2:0] diff;
  logic signed [LEVEL_W-1:0] lvl;
  logic                slot_free;

  assign t_w    = T_W'(sum_q) * T_W'(rlog_q);
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 1)'({root_q, 2'b01});
  assign fits   = rem_sh >= trial;
  assign hi     = prod_q[PROD_W-1:LEVEL_FRAC];
  assign diff   = (LEVEL_FRAC + 3)'(1) << (LEVEL_FRAC + 2);
  assign slot_free = !out_valid_q || pop_i;
  assign entry_pop_o = (state_q == ST_IDLE) && !entry_empty_i;

  always_comb begin
    lvl = '0;
    if (prod_q >= (PROD_W'(1) << (LEVEL_FRAC + 2))) begin
      if (hi > HI_W'(LEVEL_CAP + 4)) begin
        lvl = LEVEL_W'(LEVEL_CAP);
      end else begin
        lvl = LEVEL_W'(hi - HI_W'(4));
      end
    end else begin
      lvl = -LEVEL_W'((diff - (LEVEL_FRAC + 3)'(prod_q[LEVEL_FRAC+1:0])) >> LEVEL_FRAC);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!entry_empty_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SQRT;
      ST_SQRT:  if (cnt_q == '0) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_LEVEL;
      ST_LEVEL: if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o) begin
      sum_q  <= entry_i.sum;
      rlog_q <= entry_i.rlog;
      band_q <= entry_i.band;
      last_q <= entry_i.last;
    end
    if (state_q == ST_MUL) begin
      rad_q  <= RAD_W'({t_w, {ROOT_SHIFT{1'b0}}});
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CNT_W'(ROOT_W - 1);
    end else if (state_q == ST_SQRT) begin
      rad_q <= rad_q << 2;
      cnt_q <= cnt_q - CNT_W'(1);
      if (fits) begin
        rem_q  <= (REM_W - 1)'(rem_sh - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= (REM_W - 1)'(rem_sh);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (state_q == ST_SCALE) begin
      prod_q <= PROD_W'(PR_W'(gain_i) * PR_W'(root_q));
    end
    if ((state_q == ST_LEVEL) && slot_free) begin
      out_idx_q  <= IDX_W'(band_q);
      out_lvl_q  <= lvl;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_LEVEL) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o      = !out_valid_q;
  assign band_index_o = out_idx_q;
  assign band_level_o = out_lvl_q;
  assign last_band_o  = out_last_q;

endmodule

// File: hw/rtl/log_spectrum_band_binner.sv
// ----------------------------------------------------------------------------
// Log spectrum band binner
// Bins are taken one per cycle whenever full is low; a four-entry band queue
// decouples them from the level unit.
// A finished band goes through the band queue, then the level unit's multiply,
// root, scale and level states, one band at a time, its root one bit per cycle.
// Reset clears the counters, the queue and the result slot; the gain is 435.
// ----------------------------------------------------------------------------
module log_spectrum_band_binner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [lsbb_pkg::BIN_VAL_W-1:0]      bin_value_i,
  input  logic                                frame_start_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [lsbb_pkg::IDX_W-1:0]          band_index_o,
  output logic signed [lsbb_pkg::LEVEL_W-1:0] band_level_o,
  output logic                                last_band_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsbb_pkg::GAIN_W-1:0]         cfg_data_i
);
  import lsbb_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  entry_t            fe_entry, q_entry;
  logic              fe_valid, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gain_q <= cfg_data_i;
    end
  end

  lsbb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .bin_value_i   (bin_value_i),
    .frame_start_i (frame_start_i),
    .entry_o       (fe_entry),
    .entry_valid_o (fe_valid)
  );

  lsbb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .data_i  (fe_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_entry),
    .empty_o (q_empty)
  );

  lsbb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gain_i        (gain_q),
    .entry_i       (q_entry),
    .entry_empty_i (q_empty),
    .entry_pop_o   (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .band_index_o  (band_index_o),
    .band_level_o  (band_level_o),
    .last_band_o   (last_band_o)
  );

endmodule

// File: hw/rtl/lsbb_checker.sv
// ----------------------------------------------------------------------------
// Band binner port checker
// Watches the top-level ports for result range and ordering slips.
// ----------------------------------------------------------------------------
module lsbb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                empty,
  input logic                                pop,
  input logic [lsbb_pkg::IDX_W-1:0]          band_index_o,
  input logic signed [lsbb_pkg::LEVEL_W-1:0] band_level_o,
  input logic                                last_band_o
);
  import lsbb_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(band_index_o) && $stable(band_level_o)))
    else $error("result changed before it was taken");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((band_level_o >= -10'sd4) && (band_level_o <= 10'sd256)))
    else $error("band level out of range");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_band_o == (band_index_o == IDX_W'(NUM_BANDS - 1))))
    else $error("last band flag disagrees with band index");

  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (band_index_o < IDX_W'(NUM_BANDS)))
    else $error("band index beyond band count");

endmodule

bind log_spectrum_band_binner lsbb_checker u_checker (.*);

// File: tb/tb_log_spectrum_band_binner.sv
// ----------------------------------------------------------------------------
// Log spectrum band binner testbench
// Streams FFT bins through the binner in directed and random frames, predicts
// every band level in fixed point and compares each result beat field by
// field. Both sides idle at random, and the receiver stalls once for a long
// stretch so that the input queue fills up.
// ----------------------------------------------------------------------------
module tb_log_spectrum_band_binner;
  timeunit 1ns;
  timeprecision 1ps;

  import lsbb_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [IDX_W-1:0]          index;
    logic signed [LEVEL_W-1:0] level;
    logic                      last;
  } band_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic [BIN_VAL_W-1:0]      bin_value = '0;
  logic                      frame_start = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [IDX_W-1:0]          band_index;
  logic signed [LEVEL_W-1:0] band_level;
  logic                      last_band;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [GAIN_W-1:0]         cfg_data = '0;

  bit idle_en = 1'b1;
  bit long_hold_req = 1'b0;
  int err_count = 0;

  int unsigned  band_end [NUM_BANDS];
  logic [63:0]  band_rlog [NUM_BANDS];
  logic [GAIN_W-1:0] cur_gain;
  logic [31:0]  acc_sum;
  int unsigned  acc_bins;
  int unsigned  acc_band;
  band_result_t pending_bands[$];

  log_spectrum_band_binner DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .bin_value_i   (bin_value),
    .frame_start_i (frame_start),
    .empty         (empty),
    .pop           (pop),
    .band_index_o  (band_index),
    .band_level_o  (band_level),
    .last_band_o   (last_band),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic bit pow_at_most(int unsigned base, int n, int p);
    int s;
    int ex;
    logic [63:0] mb;
    logic [63:0] acc;
    logic [127:0] prod;
    s = $clog2(base + 1) - 1;
    ex = 0;
    mb = 64'(base) << (62 - s);
    acc = 64'd1 << 62;
    for (int i = 0; i < n; i++) begin
      prod = 128'(acc) * 128'(mb);
      acc = prod[125:62];
      ex = ex + s;
      if (acc[63]) begin
        acc = acc >> 1;
        ex = ex + 1;
      end
    end
    return (ex < p) || ((ex == p) && (acc == (64'd1 << 62)));
  endfunction

  function automatic logic [31:0] log2_fix28(int unsigned n);
    int k;
    logic [63:0] y;
    logic [31:0] fr;
    k = $clog2(n + 1) - 1;
    y = 64'(n) << (30 - k);
    fr = '0;
    for (int i = 27; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        fr[i] = 1'b1;
      end
    end
    return (32'(k) << 28) | fr;
  endfunction

  function automatic void build_band_tables();
    int unsigned e;
    int unsigned prev;
    int unsigned edge_v;
    logic [63:0] lq;
    e = 1;
    prev = 0;
    for (int x = 0; x < NUM_BANDS; x++) begin
      while ((e < FFT_BINS - 1) && pow_at_most(e + 1, NUM_BANDS - 1, x * EDGE_SPAN)) begin
        e++;
      end
      edge_v = (e <= prev) ? prev + 1 : e;
      lq = (64'(log2_fix28(10 + edge_v - prev)) * LOG10_2_Q32) >> 32;
      band_end[x] = edge_v;
      band_rlog[x] = ((64'd1 << 44) + lq / 2) / lq;
      prev = edge_v;
    end
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void accumulate_bin(logic [BIN_VAL_W-1:0] val, logic start);
    logic [63:0] t;
    logic [63:0] pr;
    logic [63:0] ip;
    int lvl;
    band_result_t res;
    if (start) begin
      acc_sum = '0;
      acc_bins = 0;
      acc_band = 0;
      return;
    end
    if (acc_band >= NUM_BANDS) return;
    acc_bins++;
    acc_sum = acc_sum + val;
    if (acc_bins < band_end[acc_band]) return;
    t = 64'(acc_sum) * band_rlog[acc_band];
    pr = 64'(cur_gain) * int_sqrt(t << 16);
    if (pr >= (64'd1 << 26)) begin
      ip = (pr >> 24) - 4;
      lvl = (ip > LEVEL_CAP) ? LEVEL_CAP : int'(ip);
    end else begin
      lvl = -int'(((64'd1 << 26) - pr) >> 24);
    end
    res.index = acc_band[IDX_W-1:0];
    res.level = lvl[LEVEL_W-1:0];
    res.last = (acc_band == NUM_BANDS - 1);
    pending_bands.push_back(res);
    acc_sum = '0;
    acc_band++;
  endfunction

  function automatic logic [BIN_VAL_W-1:0] rand_bin();
    return BIN_VAL_W'($urandom_range(0, 65535) >> $urandom_range(0, 16));
  endfunction

  function automatic void check_band(band_result_t got);
    band_result_t want;
    if (pending_bands.size() == 0) begin
      $display("%0t: unexpected band beat, index %0d level %0d last %0d", $time,
               got.index, $signed(got.level), got.last);
      err_count++;
      return;
    end
    want = pending_bands.pop_front();
    if (got.index != want.index) begin
      $display("%0t: band_index expected %0d, actual %0d", $time, want.index, got.index);
      err_count++;
    end
    if (got.level != want.level) begin
      $display("%0t: band_level of band %0d expected %0d, actual %0d", $time, want.index,
               $signed(want.level), $signed(got.level));
      err_count++;
    end
    if (got.last != want.last) begin
      $display("%0t: last_band of band %0d expected %0d, actual %0d", $time, want.index,
               want.last, got.last);
      err_count++;
    end
  endfunction

  task automatic send_bin(logic [BIN_VAL_W-1:0] val, logic start);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    push <= 1'b1;
    bin_value <= val;
    frame_start <= start;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    accumulate_bin(val, start);
  endtask

  task automatic drain_bands();
    push <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] g);
    drain_bands();
    cfg_valid <= 1'b1;
    cfg_data <= g;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    cur_gain = g;
  endtask

  task automatic test_reset_state();
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h8000, 1'b0);
    send_bin(16'h0001, 1'b0);
    drain_bands();
  endtask

  task automatic test_short_frames();
    logic [BIN_VAL_W-1:0] pattern [12];
    pattern = '{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
                16'h0F0F, 16'hF0F0, 16'h0001, 16'h7FFF, 16'h8000, 16'h1234};
    send_bin(16'hFFFF, 1'b1);
    foreach (pattern[i]) send_bin(pattern[i], 1'b0);
    send_bin(16'h0000, 1'b1);
    send_bin(16'h4000, 1'b0);
    send_bin(16'hC000, 1'b0);
    drain_bands();
  endtask

  task automatic test_gain_extremes();
    write_gain(16'h0000);
    send_bin(16'h0000, 1'b1);
    repeat (3) send_bin(16'hFFFF, 1'b0);
    write_gain(16'hFFFF);
    send_bin(16'h0000, 1'b1);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h0001, 1'b0);
    send_bin(16'h0000, 1'b0);
    drain_bands();
  endtask

  task automatic test_input_stall();
    write_gain(GAIN_RESET);
    idle_en = 1'b0;
    long_hold_req = 1'b1;
    send_bin(rand_bin(), 1'b1);
    repeat (24) send_bin(rand_bin(), 1'b0);
    idle_en = 1'b1;
    drain_bands();
  endtask

  task automatic test_random_frames();
    logic [GAIN_W-1:0] g;
    int sent;
    int len;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          g = 16'h0000;
        end
        1: begin
          g = 16'hFFFF;
        end
        2: begin
          g = GAIN_RESET;
        end
        default: begin
          g = GAIN_W'($urandom_range(0, 65535) >> $urandom_range(0, 10));
        end
      endcase
      write_gain(g);
      sent = 0;
      while (sent < 45) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 40);
        send_bin(rand_bin(), 1'b1);
        sent++;
        for (int j = 0; j < len; j++) begin
          send_bin(rand_bin(), $urandom_range(0, 39) == 0);
          sent++;
        end
      end
    end
    drain_bands();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    write_gain(GAIN_W'($urandom_range(0, 65535) >> $urandom_range(0, 8)));
    send_bin(rand_bin(), 1'b1);
    repeat (40) send_bin(rand_bin(), 1'b0);
    drain_bands();
  endtask

  initial begin : band_receiver
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_band({band_index, band_level, last_band});
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        pop <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 18);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    build_band_tables();
    cur_gain = GAIN_RESET;
    acc_sum = '0;
    acc_bins = 0;
    acc_band = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_short_frames();
    test_gain_extremes();
    test_input_stall();
    test_random_frames();
    test_back_to_back();
    if (err_count == 0 && pending_bands.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lsbb_pkg.sv
hw/rtl/lsbb_front.sv
hw/rtl/lsbb_fifo.sv
hw/rtl/lsbb_back.sv
hw/rtl/log_spectrum_band_binner.sv
hw/rtl/lsbb_checker.sv
tb/tb_log_spectrum_band_binner.sv
